### hdl/gdconv_pkg.sv
// shared constants, stage types and month tables for the gregorian date converter
// no dependencies; imported by the converter top level and its port checker
package gdconv_pkg;

   // field widths
   localparam int unsigned DayW   = 5;
   localparam int unsigned MonthW = 4;
   localparam int unsigned YearW  = 12;
   localparam int unsigned NumW   = 20;
   localparam int unsigned DoyW   = 9;   // day of year 0..365
   localparam int unsigned OffW   = 8;   // year - 1900, 0..200
   localparam int unsigned SpanW  = 17;  // days inside the supported window
   localparam int unsigned Q4W    = 6;   // count of 4-year cycles since 1901
   localparam int unsigned RemW   = 11;  // day inside a 4-year cycle
   localparam int unsigned FieldsW = DayW + MonthW + YearW + NumW;
   localparam int unsigned TdataW  = ((FieldsW + 7) / 8) * 8;
   localparam int unsigned PadW    = TdataW - FieldsW;

   // commands
   localparam logic CmdDateToNum = 1'b0;
   localparam logic CmdNumToDate = 1'b1;

   // range limits
   localparam logic [YearW-1:0]  YearMin  = 12'd1900;
   localparam logic [YearW-1:0]  YearMax  = 12'd2100;
   localparam logic [YearW-1:0]  Year1901 = 12'd1901;
   localparam logic [OffW-1:0]   OffEnd   = OffW'(YearMax - YearMin);
   localparam logic [MonthW-1:0] MonthFeb = 4'd2;
   localparam logic [MonthW-1:0] MonthMax = 4'd12;
   localparam logic [NumW-1:0]   NumMin   = 20'd693595;  // 1 jan 1900
   localparam logic [NumW-1:0]   NumMax   = 20'd767008;  // 31 dec 2100
   localparam logic [NumW-1:0]   Num1901  = 20'd693960;  // 1 jan 1901
   localparam logic [NumW-1:0]   Num2100  = 20'd766644;  // 1 jan 2100

   // year and cycle lengths
   localparam logic [DoyW-1:0]  DaysYear = 9'd365;
   localparam logic [RemW-1:0]  Days4y   = 11'd1461;
   localparam logic [RemW-1:0]  Rem1y    = 11'd365;
   localparam logic [RemW-1:0]  Rem2y    = 11'd730;
   localparam logic [RemW-1:0]  Rem3y    = 11'd1095;

   // span / 1461 == (span * RecipCycle) >> RecipShift, exact for the whole window
   localparam logic [SpanW-1:0] RecipCycle = 17'd91868;
   localparam int unsigned      RecipShift = 27;

   typedef struct packed {
      logic              cmd;
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [NumW-1:0]   num;
   } req_type;

   typedef struct packed {
      logic              cmd;
      logic              bad;
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [NumW-1:0]   num;
      logic [SpanW-1:0]  ybase;     // days from 1 jan 1900 to 1 jan of year
      logic [DoyW-1:0]   mpart;     // day of year of the date
      logic [SpanW-1:0]  span;      // num - 1 jan 1901
      logic [Q4W-1:0]    q4;
      logic              is_end;    // number lies in 1900 or 2100
      logic [YearW-1:0]  end_year;
      logic [DoyW-1:0]   end_doy;
   } mid_type;

   typedef struct packed {
      logic              cmd;
      logic              bad;
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [NumW-1:0]   num;
      logic [DoyW-1:0]   doy;
      logic              leap;
   } late_type;

   typedef struct packed {
      logic              invalid;
      logic [DayW-1:0]   day;
      logic [MonthW-1:0] month;
      logic [YearW-1:0]  year;
      logic [NumW-1:0]   num;
   } rsp_type;

   // zero-based start of month idx (0 = january, 12 = year length)
   function automatic logic [DoyW-1:0] month_start_f(input logic [MonthW-1:0] idx,
                                                     input logic leap);
      logic [DoyW-1:0] base;
      unique case (idx)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd59;
         4'd3:    base = 9'd90;
         4'd4:    base = 9'd120;
         4'd5:    base = 9'd151;
         4'd6:    base = 9'd181;
         4'd7:    base = 9'd212;
         4'd8:    base = 9'd243;
         4'd9:    base = 9'd273;
         4'd10:   base = 9'd304;
         4'd11:   base = 9'd334;
         4'd12:   base = 9'd365;
         default: base = 9'd0;
      endcase
      return base + DoyW'(leap && (idx >= MonthFeb));
   endfunction

   // length of month m (1 = january); zero for codes that are no month
   function automatic logic [DayW-1:0] month_len_f(input logic [MonthW-1:0] m,
                                                   input logic leap);
      logic [DayW-1:0] len;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:                                       len = leap ? 5'd29 : 5'd28;
         default:                                    len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

### hdl/gregorian_date_day_number_convert.sv
// gregorian date <-> day number converter, four register stages
// depends on gdconv_pkg for widths, limits, stage types and month tables
//
// path: a request moves through the input, stage 1, stage 2 and result registers in turn
// throughput: one request per cycle; a stage holds only while the stage after it is full and stalled
// reset: synchronous, active high; clears the four stage valid bits, payload is not reset
module gregorian_date_day_number_convert
   import gdconv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   // [4:0] day_in, [8:5] month_in, [20:9] year_in, [40:21] day_number_in, rest zero
   input  logic [TdataW-1:0] req_tdata,
   // [0] command
   input  logic              req_tuser,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // [4:0] day_out, [8:5] month_out, [20:9] year_out, [40:21] day_number_out, rest zero
   output logic [TdataW-1:0] rsp_tdata,
   // [0] invalid
   output logic              rsp_tuser
);

   // stage valid bits and the ready chain running back from the result side
   logic v0_ff, v1_ff, v2_ff, v3_ff;
   logic v0_in, v1_in, v2_in, v3_in;
   logic rdy0, rdy1, rdy2, rdy3;

   req_type  s0_ff, s0_in;
   mid_type  s1_ff, s1_in;
   late_type s2_ff, s2_in;
   rsp_type  s3_ff, s3_in;

   assign rdy3 = !v3_ff || rsp_tready;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;
   assign req_tready = rdy0;

   assign v0_in = rdy0 ? req_tvalid : v0_ff;
   assign v1_in = rdy1 ? v0_ff : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // ---------------------------------------------------------------
   // input register: unpack the request
   // ---------------------------------------------------------------
   always_comb begin
      s0_in.cmd   = req_tuser;
      s0_in.day   = req_tdata[DayW-1:0];
      s0_in.month = req_tdata[DayW +: MonthW];
      s0_in.year  = req_tdata[DayW+MonthW +: YearW];
      s0_in.num   = req_tdata[DayW+MonthW+YearW +: NumW];
   end

   always_ff @(posedge clock) begin
      if (rdy0 && req_tvalid) begin
         s0_ff <= s0_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 1: date checks and year base; number range and 4-year cycle count
   // ---------------------------------------------------------------
   logic [YearW-1:0]    year_rel;
   logic [OffW-1:0]     off;
   logic                leap_d;
   logic                date_ok;
   logic                num_ok;
   logic                before1901;
   logic                from2100;
   logic [2*SpanW-1:0]  prod;

   always_comb begin
      // years counted from 1900; 1900 and 2100 are the only non-leap multiples of 4
      year_rel = s0_ff.year - YearMin;
      off      = year_rel[OffW-1:0];
      leap_d   = (off[1:0] == 2'd0) && (off != '0) && (off != OffEnd);
      date_ok  = (s0_ff.year >= YearMin) && (s0_ff.year <= YearMax)
              && (s0_ff.month != '0) && (s0_ff.month <= MonthMax)
              && (s0_ff.day != '0)
              && (s0_ff.day <= month_len_f(s0_ff.month, leap_d));

      num_ok     = (s0_ff.num >= NumMin) && (s0_ff.num <= NumMax);
      before1901 = s0_ff.num < Num1901;
      from2100   = s0_ff.num >= Num2100;

      s1_in.cmd   = s0_ff.cmd;
      s1_in.bad   = (s0_ff.cmd == CmdNumToDate) ? !num_ok : !date_ok;
      s1_in.day   = s0_ff.day;
      s1_in.month = s0_ff.month;
      s1_in.year  = s0_ff.year;
      s1_in.num   = s0_ff.num;

      // 365 per year plus one per leap year seen before this one
      s1_in.ybase = SpanW'(off) * SpanW'(DaysYear)
                  + SpanW'((off + OffW'(3)) >> 2)
                  - SpanW'(off != '0);
      s1_in.mpart = month_start_f(s0_ff.month - MonthW'(1), leap_d)
                  + DoyW'(s0_ff.day) - DoyW'(1);

      // 1901..2099 repeat in clean 4-year cycles; divide by 1461 via reciprocal
      s1_in.span = SpanW'(s0_ff.num - Num1901);
      prod       = (2*SpanW)'(s1_in.span) * (2*SpanW)'(RecipCycle);
      s1_in.q4   = prod[RecipShift +: Q4W];

      s1_in.is_end   = before1901 || from2100;
      s1_in.end_year = before1901 ? YearMin : YearMax;
      s1_in.end_doy  = before1901 ? DoyW'(s0_ff.num - NumMin)
                                  : DoyW'(s0_ff.num - Num2100);
   end

   always_ff @(posedge clock) begin
      if (rdy1 && v0_ff) begin
         s1_ff <= s1_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 2: final day number; year and day of year from the cycle split
   // ---------------------------------------------------------------
   logic [SpanW-1:0] rem_full;
   logic [RemW-1:0]  rem;
   logic [1:0]       q1;
   logic [RemW-1:0]  rem_base;
   logic [YearW-1:0] year_n;

   always_comb begin
      rem_full = s1_ff.span - SpanW'(s1_ff.q4) * SpanW'(Days4y);
      rem      = rem_full[RemW-1:0];
      priority if (rem >= Rem3y) begin
         q1 = 2'd3;
         rem_base = Rem3y;
      end else if (rem >= Rem2y) begin
         q1 = 2'd2;
         rem_base = Rem2y;
      end else if (rem >= Rem1y) begin
         q1 = 2'd1;
         rem_base = Rem1y;
      end else begin
         q1 = 2'd0;
         rem_base = '0;
      end
      year_n = Year1901 + YearW'({s1_ff.q4, 2'b00}) + YearW'(q1);

      s2_in.cmd = s1_ff.cmd;
      s2_in.bad = s1_ff.bad;
      if (s1_ff.cmd == CmdNumToDate) begin
         s2_in.day   = '0;
         s2_in.month = '0;
         s2_in.num   = s1_ff.num;
         if (s1_ff.is_end) begin
            s2_in.year = s1_ff.end_year;
            s2_in.doy  = s1_ff.end_doy;
            s2_in.leap = 1'b0;
         end else begin
            // fourth year of each cycle is the leap year
            s2_in.year = year_n;
            s2_in.doy  = DoyW'(rem - rem_base);
            s2_in.leap = (q1 == 2'd3);
         end
      end else begin
         s2_in.day   = s1_ff.day;
         s2_in.month = s1_ff.month;
         s2_in.year  = s1_ff.year;
         s2_in.num   = NumMin + NumW'(s1_ff.ybase) + NumW'(s1_ff.mpart);
         s2_in.doy   = '0;
         s2_in.leap  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         s2_ff <= s2_in;
      end
   end

   // ---------------------------------------------------------------
   // stage 3: month lookup over the month-start table, zeroing on invalid
   // ---------------------------------------------------------------
   logic [MonthW-1:0] mon_idx;
   logic [DoyW-1:0]   dom;

   always_comb begin
      // starts rise monotonically, so the last match is the month
      mon_idx = '0;
      for (int j = 1; j < 12; j++) begin
         if (s2_ff.doy >= month_start_f(MonthW'(j), s2_ff.leap)) begin
            mon_idx = MonthW'(j);
         end
      end
      dom = s2_ff.doy - month_start_f(mon_idx, s2_ff.leap) + DoyW'(1);

      if (s2_ff.bad) begin
         s3_in = '0;
         s3_in.invalid = 1'b1;
      end else if (s2_ff.cmd == CmdNumToDate) begin
         s3_in.invalid = 1'b0;
         s3_in.day     = DayW'(dom);
         s3_in.month   = mon_idx + MonthW'(1);
         s3_in.year    = s2_ff.year;
         s3_in.num     = s2_ff.num;
      end else begin
         s3_in.invalid = 1'b0;
         s3_in.day     = s2_ff.day;
         s3_in.month   = s2_ff.month;
         s3_in.year    = s2_ff.year;
         s3_in.num     = s2_ff.num;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         s3_ff <= s3_in;
      end
   end

   // result register drives the response channel directly
   assign rsp_tvalid = v3_ff;
   assign rsp_tuser  = s3_ff.invalid;
   assign rsp_tdata  = {{PadW{1'b0}}, s3_ff.num, s3_ff.year, s3_ff.month, s3_ff.day};

endmodule

### hdl/gdconv_port_check.sv
// port-level checker for the gregorian date converter, bound to its top level
// depends on gdconv_pkg for field widths and range limits
module gdconv_port_check
   import gdconv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [TdataW-1:0] rsp_tdata,
   input logic              rsp_tuser
);

   logic [DayW-1:0]   r_day;
   logic [MonthW-1:0] r_month;
   logic [YearW-1:0]  r_year;

   assign r_day   = rsp_tdata[DayW-1:0];
   assign r_month = rsp_tdata[DayW +: MonthW];
   assign r_year  = rsp_tdata[DayW+MonthW +: YearW];

   // no result may survive a reset
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // invalid results carry all-zero fields
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("invalid response with nonzero fields");

   // valid results always name a real month and a nonzero day
   a_date_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> r_month != '0 && r_month <= MonthMax && r_day != '0)
      else $error("valid response with bad month or day");

   // valid results stay in the supported year window
   a_year_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> r_year >= YearMin && r_year <= YearMax)
      else $error("valid response outside year window");

endmodule

bind gregorian_date_day_number_convert gdconv_port_check u_gdconv_port_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/sv/gregorian_date_day_number_convert_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the gregorian date <-> day number converter: directed and random
// requests, results predicted and compared field by field in a small scoreboard class
// depends on gdconv_pkg and gregorian_date_day_number_convert
module gregorian_date_day_number_convert_tb;
   import gdconv_pkg::*;

   // cycles without any request or result moving before the run is called hung
   localparam int unsigned WatchdogLimit = 2000;
   // long receiver stall so the four stages fill and the input backs up
   localparam int unsigned HoldOffCycles = 300;
   localparam int unsigned RandomItems   = 1926;
   // margin after the last expected result, so stray results can show up
   localparam int unsigned DrainCycles   = 8;

   // field positions inside tdata, lowest bit first
   localparam int unsigned MonthLsb = DayW;
   localparam int unsigned YearLsb  = DayW + MonthW;
   localparam int unsigned NumLsb   = DayW + MonthW + YearW;

   class date_scoreboard;
      rsp_type     expected_q[$];
      int unsigned mismatches;
      int unsigned results_seen;

      function new();
         mismatches   = 0;
         results_seen = 0;
      endfunction

      static function bit leap_year(int unsigned y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      // zero-based day of year on which month index k starts; k = 12 gives the year length
      static function int unsigned month_offset(int unsigned k, bit leap);
         int unsigned base;
         case (k)
            0:       base = 0;
            1:       base = 31;
            2:       base = 59;
            3:       base = 90;
            4:       base = 120;
            5:       base = 151;
            6:       base = 181;
            7:       base = 212;
            8:       base = 243;
            9:       base = 273;
            10:      base = 304;
            11:      base = 334;
            default: base = 365;
         endcase
         return base + ((leap && k >= 2) ? 1 : 0);
      endfunction

      static function rsp_type convert(logic cmd, logic [TdataW-1:0] data);
         int unsigned d, m, y, n, p;
         int unsigned q400, q100, q4, q1, r, year, doy, k;
         bit          leap;
         rsp_type     res;
         d   = 32'(data[DayW-1:0]);
         m   = 32'(data[MonthLsb +: MonthW]);
         y   = 32'(data[YearLsb +: YearW]);
         n   = 32'(data[NumLsb +: NumW]);
         res = '0;
         if (cmd == CmdDateToNum) begin
            leap = leap_year(y);
            if (y >= 32'(YearMin) && y <= 32'(YearMax) && m >= 1 && m <= 32'(MonthMax) &&
                d >= 1 && d <= month_offset(m, leap) - month_offset(m - 1, leap)) begin
               p         = y - 1;
               res.num   = NumW'(p * 365 + p / 4 - p / 100 + p / 400
                                 + month_offset(m - 1, leap) + d - 1);
               res.day   = DayW'(d);
               res.month = MonthW'(m);
               res.year  = YearW'(y);
            end else begin
               res.invalid = 1'b1;
            end
         end else if (n < 32'(NumMin) || n > 32'(NumMax)) begin
            res.invalid = 1'b1;
         end else begin
            q400 = n / 146097;
            r    = n - q400 * 146097;
            if (r == 146096) begin
               // last day of a 400-year cycle is 31 dec of a leap year
               year = q400 * 400 + 400;
               doy  = 365;
            end else begin
               q100 = r / 36524;
               r    = r - q100 * 36524;
               q4   = r / 1461;
               r    = r - q4 * 1461;
               q1   = r / 365;
               year = q400 * 400 + q100 * 100 + q4 * 4;
               if (q1 == 4) begin
                  // last day of a 4-year cycle
                  year = year + 4;
                  doy  = 365;
               end else begin
                  year = year + q1 + 1;
                  doy  = r - q1 * 365;
               end
            end
            leap = leap_year(year);
            k    = 0;
            while (k < 11 && doy >= month_offset(k + 1, leap))
               k++;
            res.month = MonthW'(k + 1);
            res.day   = DayW'(doy - month_offset(k, leap) + 1);
            res.year  = YearW'(year);
            res.num   = NumW'(n);
         end
         return res;
      endfunction

      function void note_request(logic cmd, logic [TdataW-1:0] data);
         expected_q.push_back(convert(cmd, data));
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      task report_mismatch(string what, logic [TdataW-1:0] got, logic [TdataW-1:0] want);
         $display("result %0d: %s got 0x%0h expected 0x%0h", results_seen, what, got, want);
         mismatches++;
      endtask

      task check_result(logic [TdataW-1:0] data, logic flag);
         rsp_type want;
         results_seen++;
         if (expected_q.size() == 0) begin
            report_mismatch("result with no request outstanding, data", data, '0);
            return;
         end
         want = expected_q.pop_front();
         if (flag !== want.invalid)
            report_mismatch("invalid", TdataW'(flag), TdataW'(want.invalid));
         if (data[DayW-1:0] !== want.day)
            report_mismatch("day_out", TdataW'(data[DayW-1:0]), TdataW'(want.day));
         if (data[MonthLsb +: MonthW] !== want.month)
            report_mismatch("month_out", TdataW'(data[MonthLsb +: MonthW]), TdataW'(want.month));
         if (data[YearLsb +: YearW] !== want.year)
            report_mismatch("year_out", TdataW'(data[YearLsb +: YearW]), TdataW'(want.year));
         if (data[NumLsb +: NumW] !== want.num)
            report_mismatch("day_number_out", TdataW'(data[NumLsb +: NumW]), TdataW'(want.num));
         if (data[TdataW-1 -: PadW] !== '0)
            report_mismatch("tdata padding", TdataW'(data[TdataW-1 -: PadW]), '0);
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [TdataW-1:0] req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [TdataW-1:0] rsp_tdata;
   logic              rsp_tuser;

   // idle percentages of sender and receiver, changed between phases
   int unsigned send_idle_pct = 16;
   int unsigned recv_idle_pct = 70;
   // set by the stimulus to ask the receiver for one long stall
   bit          hold_off_request = 1'b0;

   date_scoreboard sb = new();

   gregorian_date_day_number_convert i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // pack day, month, year and day number into tdata, padding bits stay zero
   function automatic logic [TdataW-1:0] pack_fields(int unsigned d, int unsigned m,
                                                     int unsigned y, int unsigned n);
      logic [TdataW-1:0] data;
      data                     = '0;
      data[DayW-1:0]           = DayW'(d);
      data[MonthLsb +: MonthW] = MonthW'(m);
      data[YearLsb +: YearW]   = YearW'(y);
      data[NumLsb +: NumW]     = NumW'(n);
      return data;
   endfunction

   // one request: optional random gap, then hold it until the block takes it;
   // inputs only change at the falling edge, acceptance is seen at the rising edge
   task automatic send_request(logic cmd, logic [TdataW-1:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = data;
      do
         @(posedge clock);
      while (!req_tready);
      sb.note_request(cmd, data);
      @(negedge clock);
   endtask

   // date request, day number field filled with noise since it is ignored
   task automatic send_date(int unsigned d, int unsigned m, int unsigned y);
      send_request(CmdDateToNum, pack_fields(d, m, y, $urandom()));
   endtask

   // day number request, date fields filled with noise
   task automatic send_number(int unsigned n);
      send_request(CmdNumToDate, pack_fields($urandom(), $urandom(), $urandom(), n));
   endtask

   // random request, weighted toward the supported window and its edges
   task automatic send_random_item();
      int unsigned pick;
      int unsigned d, m, y, n, first_day;
      rsp_type     first_res;
      pick = $urandom_range(99);
      if ($urandom_range(1) == 0) begin
         y = (pick < 80) ? $urandom_range(1896, 2104) : $urandom();
         m = ($urandom_range(99) < 85) ? $urandom_range(1, 12) : $urandom();
         case ($urandom_range(19))
            0, 1, 2:             d = $urandom();
            3, 4, 5, 6, 7, 8, 9: d = $urandom_range(28, 31);
            default:             d = $urandom_range(1, 28);
         endcase
         send_date(d, m, y);
      end else begin
         if (pick < 45) begin
            n = $urandom_range(32'(NumMin), 32'(NumMax));
         end else if (pick < 70) begin
            // around new year and the end of february of a random year
            y         = $urandom_range(1900, 2100);
            first_res = date_scoreboard::convert(CmdDateToNum, pack_fields(1, 1, y, 0));
            first_day = 32'(first_res.num);
            case ($urandom_range(5))
               0:       n = first_day - 1;
               1:       n = first_day;
               2:       n = first_day + 1;
               3:       n = first_day + 58;
               4:       n = first_day + 59;
               default: n = first_day + 60;
            endcase
         end else if (pick < 85) begin
            n = ($urandom_range(1) == 0) ? $urandom_range(NumMin - 3, NumMin + 3)
                                         : $urandom_range(NumMax - 3, NumMax + 3);
         end else begin
            n = $urandom();
         end
         send_number(n);
      end
   endtask

   // receiver: random tready, plus one long stall when asked
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready = 1'b0;
            repeat (HoldOffCycles) @(negedge clock);
            hold_off_request = 1'b0;
         end
         rsp_tready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // every accepted result goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser);
   end

   // watchdog: cycles in a row where nothing moves on either channel
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WatchdogLimit) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("watchdog expired with %0d results outstanding", sb.pending());
      $display("Some tests failed");
      $finish;
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CmdDateToNum;
      req_tdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // date extremes and leap year rules
      send_date(1, 1, 1900);
      send_date(31, 12, 2100);
      send_date(29, 2, 2000);      // divisible by 400, leap
      send_date(29, 2, 1900);      // divisible by 100, not leap
      send_date(29, 2, 2024);
      send_date(29, 2, 2023);
      send_date(29, 2, 2100);
      send_date(0, 6, 2000);       // day zero
      send_date(31, 4, 2010);      // past the end of a 30-day month
      send_date(31, 1, 2050);
      send_date(5, 0, 2000);       // month zero
      send_date(5, 13, 2000);
      send_date(31, 15, 4095);     // every field at its top
      send_date(1, 1, 1899);
      send_date(1, 1, 2101);
      send_date(0, 0, 0);
      // day number window edges and cycle ends
      send_number(0);
      send_number(NumMin - 1);
      send_number(32'(NumMin));
      send_number(32'(NumMax));
      send_number(NumMax + 1);
      send_number(32'hfffff);
      send_number(730484);         // end of a 400-year cycle, 31 dec 2000
      send_number(731945);         // end of a 4-year cycle, 31 dec 2004
      send_number(32'(Num2100));

      // three idling phases; the last starts with the long receiver stall
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 16;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 16;
            end
            default: begin
               send_idle_pct    = 0;
               recv_idle_pct    = 0;
               hold_off_request = 1'b1;
            end
         endcase
         repeat (RandomItems / 3) send_random_item();
      end
      req_tvalid = 1'b0;

      // drain, then give stray results a chance to show up
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
hdl/gdconv_pkg.sv
hdl/gregorian_date_day_number_convert.sv
hdl/gdconv_port_check.sv
tb/sv/gregorian_date_day_number_convert_tb.sv
